>>> rtl/core/matrix_corner_region_maximum_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the corner region maximum block
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CORNER_REGION_MAXIMUM_DEFINES_SVH
`define MATRIX_CORNER_REGION_MAXIMUM_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MCRM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define MCRM_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MCRM_ASSERT(name, clk, rst_n, prop)
`define MCRM_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/mcrm_pkg.sv
// ----------------------------------------------------------------------------
// mcrm_pkg
// Shared types and constants of the corner region maximum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcrm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 4;

  // Side length after reset.
  localparam logic [SizeW-1:0] SizeReset = SizeW'(8);

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [SizeW-1:0]        size_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } mcrm_res_t;

endpackage

`default_nettype wire

>>> rtl/core/mcrm_store.sv
// ----------------------------------------------------------------------------
// mcrm_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcrm_store #(
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  mcrm_pkg::data_t     wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output mcrm_pkg::data_t     rd_data_o
);
  import mcrm_pkg::*;

  data_t mem [2**AddrW];
  data_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/core/mcrm_ctrl.sv
// ----------------------------------------------------------------------------
// mcrm_ctrl
// Load sequencer and region scanner: fills the store, then walks each
// result's region through the read port and keeps a running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcrm_ctrl #(
  parameter int unsigned IdxW = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxW-1:0]       n_last_i,
  input  logic                  cfg_clear_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  wr_en_o,
  output logic [2*IdxW-1:0]     wr_addr_o,
  output logic                  rd_en_o,
  output logic [2*IdxW-1:0]     rd_addr_o,
  input  mcrm_pkg::data_t       rd_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output mcrm_pkg::mcrm_res_t   res_o
);
  import mcrm_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [IdxW-1:0] res_row_q, res_row_d, res_col_q, res_col_d;
  logic [IdxW-1:0] a_q, a_d, b_q, b_d;
  logic            first_q, first_d;
  logic            rd_valid_q, rd_valid_d, rd_first_q, rd_first_d;
  data_t           best_q, best_d;

  logic            upper;
  logic [IdxW-1:0] r0, r1, c0, c1;
  logic            accept;

  // The current result's region depends on its side of the anti-diagonal.
  assign upper = ({1'b0, res_row_q} + {1'b0, res_col_q}) <= {1'b0, n_last_i};
  assign r0    = upper ? res_row_q : '0;
  assign c0    = upper ? res_col_q : '0;
  assign r1    = upper ? n_last_i  : res_row_q;
  assign c1    = upper ? n_last_i  : res_col_q;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign accept      = in_valid_i && in_ready_o;
  assign wr_en_o     = accept;
  assign wr_addr_o   = {ld_row_q, ld_col_q};
  assign rd_en_o     = (state_q == ST_SCAN);
  assign rd_addr_o   = {a_q, b_q};
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o.value = best_q;
  assign res_o.last  = (res_row_q == n_last_i) && (res_col_q == n_last_i);

  always_comb begin
    state_d    = state_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    res_row_d  = res_row_q;
    res_col_d  = res_col_q;
    a_d        = a_q;
    b_d        = b_q;
    first_d    = first_q;
    rd_valid_d = 1'b0;
    rd_first_d = 1'b0;
    best_d     = best_q;

    // Read data arrives in the cycle after its address.
    if (rd_valid_q) begin
      if (rd_first_q || (rd_data_i > best_q)) begin
        best_d = rd_data_i;
      end
    end

    unique case (state_q)
      ST_LOAD: begin
        if (cfg_clear_i) begin
          ld_row_d = '0;
          ld_col_d = '0;
        end else if (accept) begin
          if (ld_col_q == n_last_i) begin
            ld_col_d = '0;
            if (ld_row_q == n_last_i) begin
              ld_row_d  = '0;
              res_row_d = '0;
              res_col_d = '0;
              state_d   = ST_SETUP;
            end else begin
              ld_row_d = ld_row_q + IdxW'(1);
            end
          end else begin
            ld_col_d = ld_col_q + IdxW'(1);
          end
        end
      end
      ST_SETUP: begin
        a_d     = r0;
        b_d     = c0;
        first_d = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_valid_d = 1'b1;
        rd_first_d = first_q;
        first_d    = 1'b0;
        if (b_q == c1) begin
          b_d = c0;
          if (a_q == r1) begin
            state_d = ST_DRAIN;
          end else begin
            a_d = a_q + IdxW'(1);
          end
        end else begin
          b_d = b_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_SETUP;
          if (res_col_q == n_last_i) begin
            res_col_d = '0;
            if (res_row_q == n_last_i) begin
              res_row_d = '0;
              state_d   = ST_LOAD;
            end else begin
              res_row_d = res_row_q + IdxW'(1);
            end
          end else begin
            res_col_d = res_col_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      res_row_q  <= '0;
      res_col_q  <= '0;
      a_q        <= '0;
      b_q        <= '0;
      first_q    <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_first_q <= 1'b0;
      best_q     <= '0;
    end else begin
      state_q    <= state_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      res_row_q  <= res_row_d;
      res_col_q  <= res_col_d;
      a_q        <= a_d;
      b_q        <= b_d;
      first_q    <= first_d;
      rd_valid_q <= rd_valid_d;
      rd_first_q <= rd_first_d;
      best_q     <= best_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/matrix_corner_region_maximum.sv
// ----------------------------------------------------------------------------
// matrix_corner_region_maximum
// Corner region maximum of a square signed matrix loaded in row-major order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_valid_i/cfg_ready_o matrix_size_i
//   in        in         in_valid_i/in_ready_o   element_value_i
//   out       out        out_valid_o/out_ready_i region_max_o, last_result_o
//
// The block takes one element per cycle while it loads. For each result,
// every element of its region is then read once through the single read
// port of the element store, after a step that sets up the region walk; a
// drain step lets the last read return, and an emit step hands the result
// to the output register. Reset is asynchronous and active low; it empties
// the load counters and the output register and sets the side length to 8.
// The element store itself is not cleared. A stalled output holds the
// scanner in its emit state, and no new element is taken until the last
// result has moved into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_corner_region_maximum_defines.svh"

module matrix_corner_region_maximum #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  mcrm_pkg::size_t      matrix_size_i,
  // Element request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcrm_pkg::data_t      element_value_i,
  // Result request channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcrm_pkg::data_t      region_max_o,
  output logic                 last_result_o
);
  import mcrm_pkg::*;

  // Row and column indexes; the store is addressed as {row, column}, so its
  // layout does not depend on the side length in use.
  localparam int unsigned IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned AddrW = 2 * IdxW;

  size_t           size_q;
  logic [IdxW-1:0] n_last;
  logic            cfg_write;

  logic            wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  data_t           rd_data;

  logic            res_valid, res_ready;
  mcrm_res_t       res;

  logic            out_valid_q;
  mcrm_res_t       out_res_q;

  // The configuration register is always writable; a write also restarts
  // the load of a partly delivered matrix.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_write) begin
      size_q <= matrix_size_i;
    end
  end

  // Last row and column index: a size of zero acts as one, and anything
  // above the largest supported side acts as that side.
  always_comb begin
    if (size_q == '0) begin
      n_last = '0;
    end else if (size_q > SizeW'(MAX_DIM)) begin
      n_last = IdxW'(MAX_DIM - 1);
    end else begin
      n_last = IdxW'(size_q - SizeW'(1));
    end
  end

  mcrm_store #(
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (element_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mcrm_ctrl #(
    .IdxW (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_last_i    (n_last),
    .cfg_clear_i (cfg_write),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: the scanner hands over a result whenever the register
  // is empty or its content is being taken in the same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign region_max_o  = out_res_q.value;
  assign last_result_o = out_res_q.last;

  // Elements are never taken while the scanner holds a finished result.
  `MCRM_ASSERT_NEVER(a_load_during_emit, clk_i, rst_ni, in_ready_o && res_valid)
  // Handing over the final result reopens the element channel.
  `MCRM_ASSERT(a_reload_after_last, clk_i, rst_ni,
               (res_valid && res_ready && res.last) |=> in_ready_o)

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the corner region maximum block. Whole matrices are
// streamed in at several side lengths. A class predicts every region maximum
// and compares each result request, field by field, with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------

// Holds a private copy of the element store, the load counter and the side
// length register, and queues the expected result matrix whenever an
// accepted element completes one.
class corner_max_board;
  int unsigned          max_dim;
  mcrm_pkg::data_t      cells [64];
  bit [6:0]             loaded;
  mcrm_pkg::size_t      size_reg;
  mcrm_pkg::mcrm_res_t  pending_maxima [$];
  int unsigned          mismatches;
  int unsigned          results_seen;
  int unsigned          matrices_done;

  function new(int unsigned dim);
    max_dim       = dim;
    loaded        = '0;
    size_reg      = mcrm_pkg::SizeReset;
    mismatches    = 0;
    results_seen  = 0;
    matrices_done = 0;
    foreach (cells[i]) cells[i] = '0;
  endfunction

  // Size code zero means one; codes above the maximum are clamped.
  function int unsigned side();
    int unsigned n;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > max_dim) n = max_dim;
    return n;
  endfunction

  // A register write also throws away any partly loaded matrix.
  function void write_size(mcrm_pkg::size_t code);
    size_reg = code;
    loaded   = '0;
  endfunction

  // On or above the anti-diagonal the region runs from (r,c) to the
  // bottom-right corner, below it from the top-left corner to (r,c).
  function mcrm_pkg::data_t region_peak(int unsigned n, int unsigned r, int unsigned c);
    int unsigned     r0, r1, c0, c1, a, b;
    mcrm_pkg::data_t peak;
    if (r + c <= n - 1) begin
      r0 = r; r1 = n - 1; c0 = c; c1 = n - 1;
    end else begin
      r0 = 0; r1 = r; c0 = 0; c1 = c;
    end
    peak = cells[r0 * n + c0];
    for (a = r0; a <= r1; a++) begin
      for (b = c0; b <= c1; b++) begin
        if (cells[a * n + b] > peak) peak = cells[a * n + b];
      end
    end
    return peak;
  endfunction

  function void take_element(mcrm_pkg::data_t v);
    int unsigned         n, r, c;
    mcrm_pkg::mcrm_res_t entry;
    n = side();
    cells[loaded] = v;
    loaded++;
    if (loaded < n * n) return;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        entry.value = region_peak(n, r, c);
        entry.last  = (r == n - 1) && (c == n - 1);
        pending_maxima.push_back(entry);
      end
    end
    loaded = '0;
    matrices_done++;
  endfunction

  function void check_result(mcrm_pkg::data_t value, logic last);
    mcrm_pkg::mcrm_res_t want;
    results_seen++;
    if (pending_maxima.size() == 0) begin
      $error("Result with nothing outstanding: region_max %0d, last_result %0b", value, last);
      mismatches++;
      return;
    end
    want = pending_maxima.pop_front();
    if (value !== want.value) begin
      $error("region_max: expected %0d, actual %0d", want.value, value);
      mismatches++;
    end
    if (last !== want.last) begin
      $error("last_result: expected %0b, actual %0b", want.last, last);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_maxima.size();
  endfunction
endclass

module tb;

  // Dimension limit the block is built with.
  localparam int unsigned MaxDim = 8;
  // Number of elements after which the random part stops.
  localparam int unsigned ItemTarget = 310;
  // Quiet cycles before a register write. A partial load produces no result,
  // so the block may still be busy with a loading step when the outstanding
  // list runs dry; this is comfortably above one result's worth of work.
  localparam int unsigned SettleCycles = 80;
  // Length of the long output stall.
  localparam int unsigned HoldCycles = 400;
  // Far above the length of the worst honest run.
  localparam longint unsigned CycleLimit = 400000;

  localparam mcrm_pkg::data_t MinValue = {1'b1, {31{1'b0}}};
  localparam mcrm_pkg::data_t MaxValue = {1'b0, {31{1'b1}}};

  // Kinds of matrix content. Narrow values give many ties, the corner
  // values hit both ends of the signed range.
  typedef enum int unsigned {
    FillWide,
    FillNarrow,
    FillCorners,
    FillNegative
  } fill_e;

  logic            clk           = 1'b0;
  logic            rst_n         = 1'b0;
  logic            cfg_valid     = 1'b0;
  logic            cfg_ready;
  mcrm_pkg::size_t size_value    = '0;
  logic            in_valid      = 1'b0;
  logic            in_ready;
  mcrm_pkg::data_t element_value = '0;
  logic            out_valid;
  logic            out_ready     = 1'b0;
  mcrm_pkg::data_t region_max;
  logic            last_result;

  corner_max_board  board;
  // When set, neither side idles, so back-to-back requests are exercised.
  bit               steady      = 1'b0;
  // Asks the result side for one long stall.
  bit               hold_req    = 1'b0;
  int unsigned      items_sent  = 0;
  int unsigned      drops       = 0;
  int unsigned      long_stalls = 0;
  bit [MaxDim:0]    sides_seen  = '0;
  longint unsigned  cycle_count = 0;

  always #5 clk = ~clk;

  matrix_corner_region_maximum #(
    .MAX_DIM(MaxDim)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .matrix_size_i  (size_value),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .element_value_i(element_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .region_max_o   (region_max),
    .last_result_o  (last_result)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, board.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic mcrm_pkg::data_t pick_value(fill_e mode);
    case (mode)
      FillWide:   return $urandom;
      FillNarrow: return mcrm_pkg::data_t'($urandom_range(0, 6)) - 32'sd3;
      FillCorners: begin
        case ($urandom_range(0, 4))
          0:       return MinValue;
          1:       return MaxValue;
          2:       return -32'sd1;
          3:       return 32'sd0;
          default: return 32'sd1;
        endcase
      end
      default:    return {1'b1, 31'($urandom)};
    endcase
  endfunction

  // All driving happens at the falling edge; handshakes are sampled at the
  // rising edge. Each task is entered and left just after a falling edge.
  // Valid stays up after acceptance so that a zero gap gives back-to-back
  // requests without a dip.
  task automatic send_element(mcrm_pkg::data_t v);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    element_value = v;
    do @(posedge clk); while (!in_ready);
    board.take_element(v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_matrix(int unsigned count, fill_e mode);
    repeat (count) send_element(pick_value(mode));
  endtask

  // Stops offering elements and waits until every predicted result has
  // been taken, then lets the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_size(mcrm_pkg::size_t code);
    drain();
    cfg_valid  = 1'b1;
    size_value = code;
    do @(posedge clk); while (!cfg_ready);
    board.write_size(code);
    sides_seen[board.side()] = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random acceptance gaps, plus one long stall on request,
  // counted here so the element side keeps pushing meanwhile.
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        long_stalls++;
        repeat (HoldCycles) @(negedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(region_max, last_result);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned     n, count, pick;
    mcrm_pkg::size_t size_code;
    fill_e           mode;
    board = new(MaxDim);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // One full matrix at the side length left by reset.
    sides_seen[board.side()] = 1'b1;
    send_matrix(MaxDim * MaxDim, FillWide);

    // Size code zero acts as one: each element is a matrix of its own,
    // and both ends of the signed range pass through alone.
    write_size('0);
    send_element(MinValue);
    send_element(MaxValue);

    // Two by two with the extremes mixed in.
    write_size(mcrm_pkg::size_t'(2));
    send_element(MaxValue);
    send_element(MinValue);
    send_element(-32'sd1);
    send_element(32'sd0);

    // A partly loaded three by three is dropped by the next write, and the
    // following matrix must start again from the first element.
    write_size(mcrm_pkg::size_t'(3));
    send_matrix(5, FillWide);
    drops++;
    write_size(mcrm_pkg::size_t'(2));
    repeat (4) send_element(MinValue);

    // Long stall on the result side while three matrices are offered: the
    // block fills, its output backs up and element requests stall.
    write_size(mcrm_pkg::size_t'(4));
    hold_req = 1'b1;
    send_matrix(16, FillNarrow);
    send_matrix(16, FillWide);
    send_matrix(16, FillCorners);

    // Largest size code, clamped to the dimension limit.
    write_size(mcrm_pkg::size_t'(15));
    send_matrix(MaxDim * MaxDim, FillNegative);

    // Random phases: mostly small sides, now and then a large or clamped
    // code, and sometimes a trailing partial matrix that the next write
    // discards.
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) size_code = '0;
      else if (pick == 1) size_code = mcrm_pkg::size_t'($urandom_range(9, 15));
      else if (pick < 4) size_code = mcrm_pkg::size_t'($urandom_range(6, 8));
      else size_code = mcrm_pkg::size_t'($urandom_range(1, 5));
      steady = ($urandom_range(0, 4) == 0);
      write_size(size_code);
      n     = board.side();
      count = (n > 5) ? 1 : $urandom_range(1, 3);
      repeat (count) begin
        mode = fill_e'($urandom_range(0, 3));
        send_matrix(n * n, mode);
      end
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        send_matrix($urandom_range(1, n * n - 1), FillWide);
        drops++;
      end
    end
    steady = 1'b0;
    drain();

    $display("Checked %0d results from %0d matrices built from %0d elements, %0d partial loads dropped.",
             board.results_seen, board.matrices_done, items_sent, drops);
    $display("Side lengths reached (8 down to 1): %b, long output stalls: %0d.",
             sides_seen[MaxDim:1], long_stalls);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
